### design/htri_pkg.sv
`default_nettype none
package htri_pkg;

  // opcodes of an input word
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_INV_SPACING = 2'd2;
  localparam logic [1:0] REG_SIDE_LOG2   = 2'd3;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [16:0] ONE_Q16  = 17'h1_0000;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  typedef struct packed {
    logic        wr;
    logic        neg;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [14:0] vidx;
    logic [31:0] vh;
  } htri_item_t;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] inv_spacing;
    logic [2:0]  side_log2;
  } htri_cfg_t;

endpackage
`default_nettype wire

### design/heightfield_triangle_interpolation_top.sv
// triangulated heightfield height query
// input channel (in_valid / in_stall): a word is either a vertex write
// (in_opcode 1: in_vertex_index, in_vertex_height) that gives no result, or
// a height query (in_opcode 0: in_pos_x, in_pos_y, signed q16.16)
// result channel (out_valid / out_stall): one word per query, out_height
// in q16.16 and out_in_page; off the page the height is zero
// config port: cfg_we with cfg_index / cfg_wdata, only while idle
// throughput: one word per cycle while the queue is not full; the vertex
// store is kept in three copies, one read port each, so all three triangle
// corners are read in the same cycle; a query passes the queue, then the
// registers for multiply, cell split, weights, store read, products and the
// sum into the output register; the front subtract sits before the queue
// a four-word queue parts the front from the back pipeline; when the
// receiver stalls the back pipeline holds and the queue keeps filling,
// in_stall rises only once the queue is full
// reset clears the queue, the pipeline valids and the registers to their
// defaults; the vertex store is not cleared, so vertices are written first
`default_nettype none
module heightfield_triangle_interpolation_top
  import htri_pkg::*;
#(
  parameter int MAX_SIDE = 129
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic [14:0] in_vertex_index,
  input  wire logic signed [31:0] in_vertex_height,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_height,
  output logic             out_in_page,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  htri_cfg_t  cfg_r;
  htri_item_t f_item, q_dout;
  logic       q_push, q_pop, q_empty, q_full;
  logic [31:0] height_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= 32'd0;
      cfg_r.origin_y    <= 32'd0;
      cfg_r.inv_spacing <= 32'h0001_0000;
      cfg_r.side_log2   <= 3'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    cfg_r.origin_x    <= cfg_wdata;
        REG_ORIGIN_Y:    cfg_r.origin_y    <= cfg_wdata;
        REG_INV_SPACING: cfg_r.inv_spacing <= cfg_wdata;
        REG_SIDE_LOG2:   cfg_r.side_log2   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // front: origin offset and word classification
  htri_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_vertex_index  (in_vertex_index),
    .in_vertex_height (in_vertex_height),
    .cfg              (cfg_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (f_item)
  );

  // decoupling queue
  htri_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_item),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  // back: grid mapping, vertex store and blend
  htri_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_item      (q_dout),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_height  (height_w),
    .out_in_page (out_in_page)
  );

  assign out_height = height_w;

endmodule
`default_nettype wire

### design/htri_front.sv
`default_nettype none
module htri_front
  import htri_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [14:0] in_vertex_index,
  input  wire logic [31:0] in_vertex_height,
  input  wire htri_cfg_t   cfg,
  input  wire logic        q_full,
  output logic             q_push,
  output htri_item_t       q_item
);

  logic [32:0] dx33;
  logic [32:0] dy33;

  // offset from page origin, exact in 33 bits
  assign dx33 = {in_pos_x[31], in_pos_x} - {cfg.origin_x[31], cfg.origin_x};
  assign dy33 = {in_pos_y[31], in_pos_y} - {cfg.origin_y[31], cfg.origin_y};

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.wr   = (in_opcode == OP_WRITE);
    q_item.neg  = dx33[32] || dy33[32];
    q_item.dx   = dx33[31:0];
    q_item.dy   = dy33[31:0];
    q_item.vidx = in_vertex_index;
    q_item.vh   = in_vertex_height;
  end

endmodule
`default_nettype wire

### design/htri_fifo.sv
`default_nettype none
module htri_fifo
  import htri_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire htri_item_t din,
  input  wire logic       pop,
  output htri_item_t      dout,
  output logic            empty,
  output logic            full
);

  htri_item_t             ent_r [QDEPTH];
  logic [QPTR_W-1:0]      wp_r, wp_nxt;
  logic [QPTR_W-1:0]      rp_r, rp_nxt;
  logic [QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign dout  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("queue count overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("pop from empty queue");

endmodule
`default_nettype wire

### design/htri_back.sv
`default_nettype none
module htri_back
  import htri_pkg::*;
#(
  parameter int MAX_SIDE = 129
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire htri_cfg_t  cfg,
  input  wire logic       q_empty,
  input  wire htri_item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [31:0]     out_height,
  output logic            out_in_page
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);

  logic adv;
  logic [2:0] p_eff;

  // stage 1: grid coordinate products
  logic        s1_v_r, s1_wr_r, s1_neg_r;
  logic [63:0] s1_px_r, s1_py_r;
  logic [14:0] s1_vidx_r;
  logic [31:0] s1_vh_r;
  // stage 2: cell and fractions
  logic        s2_v_r, s2_wr_r, s2_in_r;
  logic [6:0]  s2_col_r, s2_row_r;
  logic [15:0] s2_fx_r, s2_fy_r;
  logic [14:0] s2_vidx_r;
  logic [31:0] s2_vh_r;
  logic        ok_x, ok_y;
  logic [32:0] lim;
  // stage 3: weights and addresses
  logic        s3_v_r, s3_wr_r, s3_in_r;
  logic [2:0][16:0] s3_w_r, w_nxt;
  logic [2:0][14:0] s3_a_r, a_nxt;
  logic [14:0] s3_vidx_r;
  logic [31:0] s3_vh_r;
  logic [7:0]  side;
  logic [14:0] base, a00, a10, a01, a11;
  logic [16:0] fx17, fy17, fs;
  // stage 4: vertex reads
  logic        s4_v_r, s4_wr_r, s4_in_r;
  logic [2:0][16:0] s4_w_r;
  logic [2:0]  s4_oob_r;
  logic [2:0][31:0] rd_r;
  logic        wr_en;
  // stage 5: weighted products
  logic        s5_v_r, s5_wr_r, s5_in_r;
  logic [2:0][48:0] s5_p_r;
  logic [2:0][31:0] hb;
  logic [48:0] acc;
  logic [17:0] wsum4;
  // output register
  logic        out_valid_r, out_in_page_r;
  logic [31:0] out_height_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;
  assign p_eff = (cfg.side_log2 == 3'd0) ? 3'd1 : cfg.side_log2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= {32'd0, q_item.dx} * {32'd0, cfg.inv_spacing};
      s1_py_r   <= {32'd0, q_item.dy} * {32'd0, cfg.inv_spacing};
      s1_wr_r   <= q_item.wr;
      s1_neg_r  <= q_item.neg;
      s1_vidx_r <= q_item.vidx;
      s1_vh_r   <= q_item.vh;
    end
  end

  assign lim  = 33'd1 << p_eff;
  assign ok_x = ({1'b0, s1_px_r[63:32]} < lim);
  assign ok_y = ({1'b0, s1_py_r[63:32]} < lim);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_wr_r   <= s1_wr_r;
      s2_in_r   <= !s1_neg_r && ok_x && ok_y;
      s2_col_r  <= s1_px_r[38:32];
      s2_row_r  <= s1_py_r[38:32];
      s2_fx_r   <= s1_px_r[31:16];
      s2_fy_r   <= s1_py_r[31:16];
      s2_vidx_r <= s1_vidx_r;
      s2_vh_r   <= s1_vh_r;
    end
  end

  // triangle choice: three corners, each on its own store copy
  always_comb begin
    side = (8'd1 << p_eff) + 8'd1;
    base = {8'd0, s2_col_r} + ({7'd0, side} * {8'd0, s2_row_r});
    a00  = base;
    a10  = base + 15'd1;
    a01  = base + {7'd0, side};
    a11  = base + {7'd0, side} + 15'd1;
    fx17 = {1'b0, s2_fx_r};
    fy17 = {1'b0, s2_fy_r};
    fs   = fx17 + fy17;
    if (s2_col_r[0] == s2_row_r[0]) begin
      if (fx17 > fy17) begin
        w_nxt[0] = ONE_Q16 - fx17; a_nxt[0] = a00;
        w_nxt[1] = fy17;           a_nxt[1] = a11;
        w_nxt[2] = fx17 - fy17;    a_nxt[2] = a10;
      end else begin
        w_nxt[0] = ONE_Q16 - fy17; a_nxt[0] = a00;
        w_nxt[1] = fx17;           a_nxt[1] = a11;
        w_nxt[2] = fy17 - fx17;    a_nxt[2] = a01;
      end
    end else begin
      if (fs <= ONE_Q16) begin
        w_nxt[0] = fx17;           a_nxt[0] = a10;
        w_nxt[1] = fy17;           a_nxt[1] = a01;
        w_nxt[2] = ONE_Q16 - fs;   a_nxt[2] = a00;
      end else begin
        w_nxt[0] = ONE_Q16 - fy17; a_nxt[0] = a10;
        w_nxt[1] = ONE_Q16 - fx17; a_nxt[1] = a01;
        w_nxt[2] = fs - ONE_Q16;   a_nxt[2] = a11;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_wr_r   <= s2_wr_r;
      s3_in_r   <= s2_in_r;
      s3_w_r    <= w_nxt;
      s3_a_r    <= a_nxt;
      s3_vidx_r <= s2_vidx_r;
      s3_vh_r   <= s2_vh_r;
    end
  end

  assign wr_en = adv && s3_v_r && s3_wr_r && (s3_vidx_r < 15'(DEPTH));

  for (genvar k = 0; k < 3; k++) begin : g_copy
    logic [31:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[s3_vidx_r[ADDR_W-1:0]] <= s3_vh_r;
      end
      if (adv) begin
        rd_r[k] <= mem[s3_a_r[k][ADDR_W-1:0]];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        s4_oob_r[k] <= (s3_a_r[k] >= 15'(DEPTH));
      end
    end
    // height biased by 2^31 so the blend stays unsigned
    assign hb[k] = s4_oob_r[k] ? SIGN_BIT : (rd_r[k] ^ SIGN_BIT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_wr_r <= s3_wr_r;
      s4_in_r <= s3_in_r;
      s4_w_r  <= s3_w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_wr_r <= s4_wr_r;
      s5_in_r <= s4_in_r;
      for (int k = 0; k < 3; k++) begin
        s5_p_r[k] <= {32'd0, s4_w_r[k]} * {17'd0, hb[k]};
      end
    end
  end

  assign acc = s5_p_r[0] + s5_p_r[1] + s5_p_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_in_page_r <= s5_in_r;
      out_height_r  <= s5_in_r ? (acc[47:16] ^ SIGN_BIT) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= q_pop;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      out_valid_r <= s5_v_r && !s5_wr_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_height  = out_height_r;
  assign out_in_page = out_in_page_r;

  assign wsum4 = {1'b0, s4_w_r[0]} + {1'b0, s4_w_r[1]} + {1'b0, s4_w_r[2]};

  a_wsum: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !s4_wr_r && s4_in_r |-> wsum4 == 18'h1_0000)
    else $error("blend weights do not sum to one");
  a_off_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_in_page_r |-> out_height_r == 32'd0)
    else $error("off-page word with non-zero height");
  a_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s5_v_r && s5_wr_r |=> !out_valid_r)
    else $error("vertex write produced a result");

endmodule
`default_nettype wire
